FILE: hdl/u8d_pkg.sv
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    // register indexes
    localparam logic REG_MAX_SEQ_LEN = 1'b0;
    localparam logic REG_CHAR_LIMIT  = 1'b1;

    localparam logic [LEN_W-1:0] MAX_SEQ_LEN_RST = 3'd3;
    localparam logic [CNT_W-1:0] CHAR_LIMIT_RST  = 16'd0;
    localparam logic [CNT_W-1:0] CNT_MAX         = 16'hffff;

    localparam logic [BYTE_W-1:0] CONT_TAG_MASK = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_TAG      = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_PAYLOAD  = 8'h3f;
    localparam logic [BYTE_W-1:0] TERMINATOR    = 8'h00;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // sequence length given by a lead byte, 0 for a byte that cannot lead
    function automatic len_t lead_length(input byte_t b);
        len_t len;
        case (b) inside
            [8'h00:8'h7f]: len = 3'd1;
            [8'hc2:8'hdf]: len = 3'd2;
            [8'he0:8'hef]: len = 3'd3;
            [8'hf0:8'hf7]: len = 3'd4;
            [8'hf8:8'hfb]: len = 3'd5;
            [8'hfc:8'hfd]: len = 3'd6;
            default:       len = 3'd0;
        endcase
        return len;
    endfunction

    // payload bits of the lead byte
    function automatic byte_t lead_payload_mask(input len_t len);
        byte_t m;
        case (len)
            3'd1:    m = 8'h7f;
            3'd2:    m = 8'h1f;
            3'd3:    m = 8'h0f;
            3'd4:    m = 8'h07;
            3'd5:    m = 8'h03;
            3'd6:    m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // bits of the second byte that must not all be zero
    function automatic byte_t lead_overlong_mask(input byte_t b);
        byte_t m;
        case (b)
            8'he0:   m = 8'h20;
            8'hf0:   m = 8'h30;
            8'hf8:   m = 8'h38;
            8'hfc:   m = 8'h3c;
            default: m = 8'h80;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/u8d_stream_if.sv
`default_nettype none

interface u8d_text_if;
    logic                        valid;
    logic                        ready;
    logic [u8d_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_char_if;
    logic                        valid;
    logic                        ready;
    logic [u8d_pkg::CP_W-1:0]    code_point;
    logic                        is_end;
    logic                        error;
    logic [u8d_pkg::CNT_W-1:0]   char_count;

    modport source (output valid, output code_point, output is_end, output error,
                    output char_count, input ready);
    modport sink   (input valid, input code_point, input is_end, input error,
                    input char_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/utf8_stream_decoder.sv
`default_nettype none

// channel   | role   | request carries
// ----------+--------+---------------------------------------------------
// text      | sink   | in_byte: one byte of utf-8 text, 0 ends a string
// chars     | source | code_point, is_end, error, char_count
// apb       | slave  | max_seq_len at 0x0, char_limit at 0x4
//
// one byte per cycle while results are taken: byte register, one pass of
// decode logic, result register; a byte's result is registered as the byte
// leaves the byte stage, which advances whenever the result register is
// empty or being taken, so a stalled result holds only the stages behind it
// rst_n clears the decode state, the valid flags and the registers to
// max_seq_len 3 and char_limit 0
// a byte that causes no result simply retires from the byte stage

module utf8_stream_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    u8d_text_if.sink                           text,
    u8d_char_if.source                         chars,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u8d_pkg::APB_AW-1:0]    paddr,
    input  wire logic [u8d_pkg::APB_DW-1:0]    pwdata,
    output logic      [u8d_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    // decoder run modes
    localparam logic [u8d_pkg::MODE_W-1:0] MODE_ACTIVE = 2'd0;
    localparam logic [u8d_pkg::MODE_W-1:0] MODE_SKIP   = 2'd1;
    localparam logic [u8d_pkg::MODE_W-1:0] MODE_DONE   = 2'd2;

    // configuration registers
    u8d_pkg::len_t                 max_seq_len_reg;
    logic [u8d_pkg::CNT_W-1:0]     char_limit_reg;

    // byte stage
    logic                          s1_valid_reg;
    u8d_pkg::byte_t                s1_byte_reg;
    logic                          s1_adv;

    // decode state
    u8d_pkg::len_t                 bytes_rem_reg, bytes_rem_next;
    u8d_pkg::len_t                 seq_idx_reg, seq_idx_next;
    u8d_pkg::byte_t                ol_mask_reg, ol_mask_next;
    logic [u8d_pkg::CP_W-1:0]      acc_reg, acc_next;
    logic [u8d_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [u8d_pkg::MODE_W-1:0]    mode_reg, mode_next;

    // result register
    logic                          out_valid_reg;
    logic [u8d_pkg::CP_W-1:0]      out_cp_reg, out_cp_next;
    logic                          out_end_reg, out_end_next;
    logic                          out_err_reg, out_err_next;
    logic [u8d_pkg::CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                          emit;

    // decode helpers
    u8d_pkg::len_t                 lead_len;
    logic [u8d_pkg::CNT_W-1:0]     count_inc;
    logic [u8d_pkg::CP_W-1:0]      acc_shift;
    logic                          cfg_wr;
    logic                          bad_end;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seq_len_reg <= u8d_pkg::MAX_SEQ_LEN_RST;
            char_limit_reg  <= u8d_pkg::CHAR_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            // register index is the word address; low byte bits are ignored
            case (paddr[2])
                u8d_pkg::REG_MAX_SEQ_LEN: max_seq_len_reg <= pwdata[u8d_pkg::LEN_W-1:0];
                u8d_pkg::REG_CHAR_LIMIT:  char_limit_reg  <= pwdata[u8d_pkg::CNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            u8d_pkg::REG_MAX_SEQ_LEN:
                prdata = {{(u8d_pkg::APB_DW-u8d_pkg::LEN_W){1'b0}}, max_seq_len_reg};
            u8d_pkg::REG_CHAR_LIMIT:
                prdata = {{(u8d_pkg::APB_DW-u8d_pkg::CNT_W){1'b0}}, char_limit_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // byte stage moves on when the result slot is free or being emptied
    assign s1_adv      = !out_valid_reg || chars.ready;
    assign text.ready  = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (text.ready)
            s1_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
            s1_byte_reg <= text.in_byte;
    end

    // ---------------- decode pass ----------------
    assign lead_len  = u8d_pkg::lead_length(s1_byte_reg);
    assign count_inc = (count_reg == u8d_pkg::CNT_MAX) ? count_reg
                                                       : count_reg + 1'b1;
    // six payload bits enter at the bottom, the top bits fall off
    assign acc_shift = {acc_reg[u8d_pkg::CP_W-7:0],
                        s1_byte_reg[5:0] & u8d_pkg::CONT_PAYLOAD[5:0]};
    // an active string that ends mid-sequence, or any skipping string, is bad
    assign bad_end   = (mode_reg == MODE_ACTIVE) ? (bytes_rem_reg != '0)
                                                 : (mode_reg != MODE_DONE);

    always_comb
    begin
        bytes_rem_next = bytes_rem_reg;
        seq_idx_next   = seq_idx_reg;
        ol_mask_next   = ol_mask_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        emit           = 1'b0;
        out_cp_next    = '0;
        out_end_next   = 1'b0;
        out_err_next   = 1'b0;
        out_cnt_next   = '0;

        if (s1_byte_reg == u8d_pkg::TERMINATOR)
        begin
            // end of string: report and start fresh
            emit           = 1'b1;
            out_end_next   = 1'b1;
            out_err_next   = bad_end;
            out_cnt_next   = bad_end ? '0 : count_reg;
            bytes_rem_next = '0;
            seq_idx_next   = '0;
            ol_mask_next   = '0;
            acc_next       = '0;
            count_next     = '0;
            mode_next      = MODE_ACTIVE;
        end
        else if (mode_reg != MODE_ACTIVE)
        begin
            // skipping or past the limit: drop the byte
        end
        else if (bytes_rem_reg == '0)
        begin
            // lead byte
            if (char_limit_reg != '0 && count_reg >= char_limit_reg)
                mode_next = MODE_DONE;
            else if (lead_len == '0 || lead_len > max_seq_len_reg)
                mode_next = MODE_SKIP;
            else if (lead_len == 3'd1)
            begin
                emit        = 1'b1;
                count_next  = count_inc;
                out_cp_next = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}},
                               s1_byte_reg & u8d_pkg::lead_payload_mask(lead_len)};
                acc_next    = '0;
            end
            else
            begin
                acc_next       = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}},
                                  s1_byte_reg & u8d_pkg::lead_payload_mask(lead_len)};
                bytes_rem_next = lead_len - 1'b1;
                seq_idx_next   = 3'd1;
                ol_mask_next   = (lead_len >= 3'd3) ? u8d_pkg::lead_overlong_mask(s1_byte_reg)
                                                    : '0;
            end
        end
        else if ((seq_idx_reg == 3'd1 && ol_mask_reg != '0 &&
                  (ol_mask_reg & s1_byte_reg) == '0) ||
                 ((s1_byte_reg & u8d_pkg::CONT_TAG_MASK) != u8d_pkg::CONT_TAG))
        begin
            // overlong form or bad continuation
            bytes_rem_next = '0;
            seq_idx_next   = '0;
            ol_mask_next   = '0;
            acc_next       = '0;
            mode_next      = MODE_SKIP;
        end
        else if (bytes_rem_reg == 3'd1)
        begin
            // last continuation completes the character
            emit           = 1'b1;
            count_next     = count_inc;
            out_cp_next    = acc_shift;
            bytes_rem_next = '0;
            seq_idx_next   = '0;
            ol_mask_next   = '0;
            acc_next       = '0;
        end
        else
        begin
            acc_next       = acc_shift;
            bytes_rem_next = bytes_rem_reg - 1'b1;
            seq_idx_next   = seq_idx_reg + 1'b1;
        end
    end

    // state commits only when the byte in the stage retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_rem_reg <= '0;
            seq_idx_reg   <= '0;
            ol_mask_reg   <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            mode_reg      <= MODE_ACTIVE;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            bytes_rem_reg <= bytes_rem_next;
            seq_idx_reg   <= seq_idx_next;
            ol_mask_reg   <= ol_mask_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_valid_reg && emit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg && emit)
        begin
            out_cp_reg  <= out_cp_next;
            out_end_reg <= out_end_next;
            out_err_reg <= out_err_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    assign chars.valid      = out_valid_reg;
    assign chars.code_point = out_cp_reg;
    assign chars.is_end     = out_end_reg;
    assign chars.error      = out_err_reg;
    assign chars.char_count = out_cnt_reg;

    // ---------------- checks ----------------
    a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg && out_err_reg |-> out_cnt_reg == '0)
        else $error("error end item with nonzero count");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_end_reg |-> !out_err_reg && out_cnt_reg == '0)
        else $error("character item with end fields set");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("unused run mode reached");

    a_seq_track: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_rem_reg == '0) == (seq_idx_reg == '0))
        else $error("sequence index out of step with remaining count");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_adv && s1_byte_reg == u8d_pkg::TERMINATOR |=>
        bytes_rem_reg == '0 && count_reg == '0 && mode_reg == MODE_ACTIVE)
        else $error("state not cleared after terminator");

endmodule

`default_nettype wire

FILE: tb/sv/tb_utf8_stream_decoder.sv
`default_nettype none

// testbench for utf8_stream_decoder
// text requests carry one byte each; every accepted byte runs through a local
// six-byte utf-8 decoder whose char or end-of-string items are queued and
// compared field by field with each char request taken from the block

module tb_utf8_stream_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // one result item as the chars channel carries it
    typedef struct packed {
        logic [u8d_pkg::CP_W-1:0]  code_point;
        logic                      is_end;
        logic                      error;
        logic [u8d_pkg::CNT_W-1:0] char_count;
    } char_item_t;

    // decoder run state: decoding, dropping bytes after a fault, past the limit
    typedef enum logic [u8d_pkg::MODE_W-1:0] {
        DEC_ACTIVE,
        DEC_SKIPPING,
        DEC_LIMITED
    } decode_mode_e;

    localparam int DRAIN_CYCLES      = 4;     // settling margin once the expected items are out
    localparam int STALL_LIMIT       = 1000;  // cycles with no handshake or register access at all
    localparam int BYTES_PER_SETTING = 88;

    // register settings walked through by the random phases, four per phase
    localparam int unsigned MAX_LEN_SETTINGS [12] = '{6, 3, 7, 0, 1, 2, 4, 5, 6, 7, 3, 6};
    localparam int unsigned LIMIT_SETTINGS   [12] =
        '{0, 0, 1, 65535, 3, 0, 5, 0, 2, 0, 65535, 4};

    // shortest and longest code point that each sequence length can carry
    localparam int unsigned CP_LOW  [6] = '{'h1, 'h80, 'h800, 'h10000, 'h200000, 'h4000000};
    localparam int unsigned CP_HIGH [6] =
        '{'h7f, 'h7ff, 'hffff, 'h1fffff, 'h3ffffff, 'h7fffffff};

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [u8d_pkg::APB_AW-1:0]  paddr;
    logic [u8d_pkg::APB_DW-1:0]  pwdata;
    logic [u8d_pkg::APB_DW-1:0]  prdata;
    logic                        pready;

    u8d_text_if text_ch ();
    u8d_char_if char_ch ();

    utf8_stream_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .chars   (char_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // idle percentages for the byte sender and the char receiver
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    int error_count    = 0;
    int bytes_accepted = 0;

    // decoded items still to come out of the block, oldest first
    char_item_t expected_chars [$];

    // local copy of the registers and the decode state, all at reset values
    u8d_pkg::len_t             cfg_max_len    = u8d_pkg::MAX_SEQ_LEN_RST;
    logic [u8d_pkg::CNT_W-1:0] cfg_char_limit = u8d_pkg::CHAR_LIMIT_RST;
    u8d_pkg::len_t             st_remaining   = '0;
    u8d_pkg::len_t             st_index       = '0;
    u8d_pkg::byte_t            st_ovl_mask    = '0;
    logic [u8d_pkg::CP_W-1:0]  st_acc         = '0;
    logic [u8d_pkg::CNT_W-1:0] st_count       = '0;
    decode_mode_e              st_mode        = DEC_ACTIVE;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t: %s", $time, what);
    endtask

    function automatic void clear_sequence();
        st_remaining = '0;
        st_index     = '0;
        st_ovl_mask  = '0;
        st_acc       = '0;
    endfunction

    // advance the local decoder by one byte; returns 1 when an item comes out
    function automatic bit decode_byte(input u8d_pkg::byte_t b, output char_item_t item);
        u8d_pkg::len_t seq_len;
        bit            malformed;
        item = '0;

        // terminator: report the string and start over
        if (b == u8d_pkg::TERMINATOR)
        begin
            malformed = (st_mode == DEC_ACTIVE) ? (st_remaining != 0)
                                                : (st_mode != DEC_LIMITED);
            item.is_end     = 1'b1;
            item.error      = malformed;
            item.char_count = malformed ? '0 : st_count;
            clear_sequence();
            st_count = '0;
            st_mode  = DEC_ACTIVE;
            return 1'b1;
        end

        // skipping and past-limit strings drop everything up to the terminator
        if (st_mode != DEC_ACTIVE)
            return 1'b0;

        if (st_remaining == 0)
        begin
            // limit is checked only when a new character would start
            if (cfg_char_limit != 0 && st_count >= cfg_char_limit)
            begin
                st_mode = DEC_LIMITED;
                return 1'b0;
            end
            casez (b)
                8'b0???????: seq_len = 3'd1;
                // c0 and c1 could only start overlong two-byte forms
                8'b110?????: seq_len = (b[4:1] == 4'b0000) ? 3'd0 : 3'd2;
                8'b1110????: seq_len = 3'd3;
                8'b11110???: seq_len = 3'd4;
                8'b111110??: seq_len = 3'd5;
                8'b1111110?: seq_len = 3'd6;
                default:     seq_len = 3'd0;
            endcase
            if (seq_len == 0 || seq_len > cfg_max_len)
            begin
                st_mode = DEC_SKIPPING;
                return 1'b0;
            end
            if (seq_len == 1)
            begin
                if (st_count != u8d_pkg::CNT_MAX)
                    st_count++;
                item.code_point = u8d_pkg::CP_W'(b[6:0]);
                return 1'b1;
            end
            st_acc       = u8d_pkg::CP_W'(b & (8'hff >> (seq_len + 1)));
            st_remaining = seq_len - 3'd1;
            st_index     = 3'd1;
            // minimal leads need some payload in the second byte
            if (seq_len >= 3)
            begin
                case (b)
                    8'he0:   st_ovl_mask = 8'h20;
                    8'hf0:   st_ovl_mask = 8'h30;
                    8'hf8:   st_ovl_mask = 8'h38;
                    8'hfc:   st_ovl_mask = 8'h3c;
                    default: st_ovl_mask = 8'h80;
                endcase
            end
            else
                st_ovl_mask = '0;
            return 1'b0;
        end

        // continuation byte
        if ((st_index == 1 && st_ovl_mask != 0 && (st_ovl_mask & b) == 0) ||
            (b & u8d_pkg::CONT_TAG_MASK) != u8d_pkg::CONT_TAG)
        begin
            clear_sequence();
            st_mode = DEC_SKIPPING;
            return 1'b0;
        end
        st_acc       = {st_acc[u8d_pkg::CP_W-7:0], b[5:0]};
        st_remaining = st_remaining - 3'd1;
        st_index     = st_index + 3'd1;
        if (st_remaining == 0)
        begin
            if (st_count != u8d_pkg::CNT_MAX)
                st_count++;
            item.code_point = st_acc;
            clear_sequence();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // present one byte, idling first at random, and predict once it is taken
    task automatic send_byte(input u8d_pkg::byte_t b);
        char_item_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            text_ch.valid   <= 1'b0;
            text_ch.in_byte <= u8d_pkg::byte_t'($urandom);
            @(posedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.in_byte <= b;
        do @(posedge clk); while (!text_ch.ready);
        bytes_accepted++;
        if (decode_byte(b, predicted))
            expected_chars.push_back(predicted);
    endtask

    // stop sending, let every expected item out, then let the pipe settle
    task automatic wait_decoder_idle();
        text_ch.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_register(input logic reg_index,
                                  input logic [u8d_pkg::APB_DW-1:0] value);
        logic [u8d_pkg::APB_DW-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write lands at this edge
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_index == u8d_pkg::REG_MAX_SEQ_LEN)
        begin
            cfg_max_len = value[u8d_pkg::LEN_W-1:0];
            if (readback[u8d_pkg::LEN_W-1:0] != cfg_max_len)
                report_mismatch($sformatf("max_seq_len reads %0d, wrote %0d",
                                          readback[u8d_pkg::LEN_W-1:0], cfg_max_len));
        end
        else
        begin
            cfg_char_limit = value[u8d_pkg::CNT_W-1:0];
            if (readback[u8d_pkg::CNT_W-1:0] != cfg_char_limit)
                report_mismatch($sformatf("char_limit reads %0d, wrote %0d",
                                          readback[u8d_pkg::CNT_W-1:0], cfg_char_limit));
        end
    endtask

    // random string: mostly well-formed characters of random length, some
    // overlong, some with a byte replaced, dropped or added
    task automatic send_random_string();
        u8d_pkg::byte_t text_bytes [$];
        int unsigned    cp;
        int             n_chars;
        int             seq_len;
        int             top_len;
        int             i;
        u8d_pkg::byte_t tag;
        u8d_pkg::byte_t lead_payload;

        n_chars = $urandom_range(8, 0);
        top_len = (cfg_max_len >= 1 && cfg_max_len <= 6) ? int'(cfg_max_len) : 6;
        repeat (n_chars)
        begin
            seq_len = ($urandom_range(3) != 0) ? $urandom_range(top_len, 1)
                                               : $urandom_range(6, 1);
            case ($urandom_range(15))
                0:       cp = CP_LOW[seq_len-1];
                1:       cp = CP_HIGH[seq_len-1];
                // overlong: a value short enough for a shorter form
                2:       cp = (seq_len == 1) ? CP_LOW[0]
                                             : $urandom_range(CP_LOW[seq_len-1] - 1, 0);
                default: cp = $urandom_range(CP_HIGH[seq_len-1], CP_LOW[seq_len-1]);
            endcase
            if (seq_len == 1)
                text_bytes.push_back(u8d_pkg::byte_t'(cp));
            else
            begin
                tag          = 8'hff << (8 - seq_len);
                lead_payload = u8d_pkg::byte_t'(cp >> (6 * (seq_len - 1)));
                text_bytes.push_back(tag | lead_payload);
                for (i = seq_len - 2; i >= 0; i--)
                    text_bytes.push_back(u8d_pkg::CONT_TAG |
                                         (u8d_pkg::byte_t'(cp >> (6 * i)) &
                                          u8d_pkg::CONT_PAYLOAD));
            end
        end

        case ($urandom_range(9))
            0: if (text_bytes.size() != 0)
                   text_bytes[$urandom_range(text_bytes.size() - 1)] =
                       u8d_pkg::byte_t'($urandom_range(255, 1));
            1: if (text_bytes.size() != 0)
                   void'(text_bytes.pop_back());
            2: text_bytes.insert($urandom_range(text_bytes.size()),
                                 u8d_pkg::byte_t'($urandom_range(255, 1)));
            default: ;
        endcase

        foreach (text_bytes[k])
            send_byte(text_bytes[k]);
        send_byte(u8d_pkg::TERMINATOR);
    endtask

    // hand-picked strings: extremes of the one-, two-, three- and six-byte forms, every rejection path,
    // empty string, terminator mid-sequence and the character limit
    task automatic test_directed_strings();
        // four-byte form against the reset length of 3
        u8d_pkg::byte_t too_long [$] = '{8'hf4, 8'h80, 8'h80, 8'h80, 8'h00};
        u8d_pkg::byte_t mixed [$] = '{
            8'h00,                                              // empty string
            8'h7f, 8'hc2, 8'h80, 8'hef, 8'hbf, 8'hbf,
            8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'h00,
            8'he0, 8'h80, 8'h00,                                // overlong
            8'hff, 8'h00,                                       // bad lead
            8'hc2, 8'h41, 8'h00,                                // bad continuation
            8'he1, 8'h80, 8'h00                                 // cut short
        };
        u8d_pkg::byte_t over_limit [$] = '{8'h41, 8'h42, 8'h00};

        foreach (too_long[k])
            send_byte(too_long[k]);
        wait_decoder_idle();
        write_register(u8d_pkg::REG_MAX_SEQ_LEN, 32'd6);
        write_register(u8d_pkg::REG_CHAR_LIMIT, 32'd0);
        foreach (mixed[k])
            send_byte(mixed[k]);
        wait_decoder_idle();
        write_register(u8d_pkg::REG_CHAR_LIMIT, 32'd1);
        foreach (over_limit[k])
            send_byte(over_limit[k]);
        wait_decoder_idle();
    endtask

    // random strings under four register settings from the table
    task automatic test_random_strings(input int src_pct, input int sink_pct,
                                       input int first_setting);
        int start_count;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int s = first_setting; s < first_setting + 4; s++)
        begin
            wait_decoder_idle();
            write_register(u8d_pkg::REG_MAX_SEQ_LEN, MAX_LEN_SETTINGS[s]);
            write_register(u8d_pkg::REG_CHAR_LIMIT, LIMIT_SETTINGS[s]);
            start_count = bytes_accepted;
            while (bytes_accepted - start_count < BYTES_PER_SETTING)
                send_random_string();
        end
        wait_decoder_idle();
    endtask

    // receiver side: random back-pressure on char requests
    initial
    begin
        forever
        begin
            @(posedge clk);
            char_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // compare each char request taken with the oldest prediction
    initial
    begin
        char_item_t got;
        char_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && char_ch.valid && char_ch.ready)
            begin
                got.code_point = char_ch.code_point;
                got.is_end     = char_ch.is_end;
                got.error      = char_ch.error;
                got.char_count = char_ch.char_count;
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected item cp=%h end=%b err=%b cnt=%0d",
                                              got.code_point, got.is_end, got.error,
                                              got.char_count));
                else
                begin
                    want = expected_chars.pop_front();
                    if (got.code_point != want.code_point)
                        report_mismatch($sformatf("code_point %h, expected %h",
                                                  got.code_point, want.code_point));
                    if (got.is_end != want.is_end)
                        report_mismatch($sformatf("is_end %b, expected %b",
                                                  got.is_end, want.is_end));
                    if (got.error != want.error)
                        report_mismatch($sformatf("error %b, expected %b",
                                                  got.error, want.error));
                    if (got.char_count != want.char_count)
                        report_mismatch($sformatf("char_count %0d, expected %0d",
                                                  got.char_count, want.char_count));
                end
            end
        end
    end

    // hang guard: too long without any request or register access
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (char_ch.valid && char_ch.ready) || psel)
                stalled = 0;
            else
                stalled++;
        end
        $display("tb_utf8_stream_decoder: errors");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        text_ch.valid   = 1'b0;
        text_ch.in_byte = '0;
        char_ch.ready   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 37;
        sink_idle_pct = 76;
        test_directed_strings();
        test_random_strings(37, 76, 0);
        test_random_strings(76, 37, 4);
        test_random_strings(0, 0, 8);

        wait_decoder_idle();
        if (error_count == 0)
            $display("tb_utf8_stream_decoder: clean");
        else
            $display("tb_utf8_stream_decoder: errors");
        $finish;
    end

endmodule

`default_nettype wire
